### hw/rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

  // Operand and result width, fraction bits (signed fixed point).
  localparam int unsigned W    = 32;
  localparam int unsigned FRAC = 16;

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_e;

  // How the back part handles a transaction.
  typedef enum logic [1:0] {
    KIND_FAST,  // add, subtract, divide by zero: result registered straight from the head
    KIND_MUL,   // products then combine
    KIND_DIV    // products then long division
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    cmd_e         cmd;
    logic         dz;
    logic [W-1:0] a_re;
    logic [W-1:0] a_im;
    logic [W-1:0] b_re;
    logic [W-1:0] b_im;
  } item_t;

  // Handshake between queue and back part.
  typedef struct packed {
    logic pop;
  } deq_t;

endpackage

### hw/rtl/cau_front.sv
// Front part: classifies an incoming transaction for the back part.
module cau_front (
  input  logic [1:0]            cmd_i,
  input  logic [cau_pkg::W-1:0] a_re_i,
  input  logic [cau_pkg::W-1:0] a_im_i,
  input  logic [cau_pkg::W-1:0] b_re_i,
  input  logic [cau_pkg::W-1:0] b_im_i,
  output cau_pkg::item_t        item_o
);

  logic b_zero;

  // Zero divisor detect
  assign b_zero = (b_re_i == '0) && (b_im_i == '0);

  always_comb begin
    item_o.cmd  = cau_pkg::cmd_e'(cmd_i);
    item_o.a_re = a_re_i;
    item_o.a_im = a_im_i;
    item_o.b_re = b_re_i;
    item_o.b_im = b_im_i;
    item_o.dz   = 1'b0;
    item_o.kind = cau_pkg::KIND_FAST;
    case (cau_pkg::cmd_e'(cmd_i))
      cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: item_o.kind = cau_pkg::KIND_FAST;
      cau_pkg::CMD_MUL: item_o.kind = cau_pkg::KIND_MUL;
      cau_pkg::CMD_DIV: begin
        item_o.dz   = b_zero;
        item_o.kind = b_zero ? cau_pkg::KIND_FAST : cau_pkg::KIND_DIV;
      end
      default: item_o.kind = cau_pkg::KIND_FAST;
    endcase
  end

endmodule

### hw/rtl/cau_queue.sv
// Short queue of classified transactions between front and back.
module cau_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cau_pkg::item_t item_i,
  input  cau_pkg::deq_t  deq_i,
  output cau_pkg::item_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned CW = $clog2(cau_pkg::QDEPTH + 1);

  cau_pkg::item_t              mem_q [cau_pkg::QDEPTH];
  logic [cau_pkg::QPW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = deq_i.pop && !empty_o;
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(cau_pkg::QDEPTH));
  assign head_o  = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == cau_pkg::QPW'(cau_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == cau_pkg::QPW'(cau_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/cau_back.sv
// Back part: executes add, subtract, multiply and divide, saturates results.
module cau_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cau_pkg::item_t        head_i,
  input  logic                  empty_i,
  output cau_pkg::deq_t         deq_o,
  output logic                  valid_o,
  output logic [cau_pkg::W-1:0] y_re_o,
  output logic [cau_pkg::W-1:0] y_im_o,
  output logic                  div_zero_o,
  output logic                  overflow_o
);

  localparam int unsigned W    = cau_pkg::W;
  localparam int unsigned F    = cau_pkg::FRAC;
  localparam int unsigned PW   = 2 * W;        // product width
  localparam int unsigned NW   = PW + 1;       // sum of two products
  localparam int unsigned MW   = NW - F;       // shifted product sum
  localparam int unsigned DVW  = NW + F;       // dividend magnitude
  localparam int unsigned CNTW = $clog2(DVW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIN
  } state_e;

  // Returns {overflow, value} for a sign-extended wide value.
  function automatic logic [W:0] sat(input logic [MW-1:0] v);
    logic [W:0] r;
    if ((v[MW-1:W-1] == '0) || (v[MW-1:W-1] == '1)) begin
      r = {1'b0, v[W-1:0]};
    end else begin
      r = {1'b1, v[MW-1], {(W-1){~v[MW-1]}}};
    end
    return r;
  endfunction

  // Applies sign to a quotient magnitude and saturates: {overflow, value}.
  function automatic logic [W:0] fin(input logic neg, input logic big,
                                     input logic [W:0] q);
    logic [W:0] r;
    logic       ov;
    if (neg) begin
      ov = big || q[W] || (q[W-1] && (q[W-2:0] != '0));
      r  = ov ? {1'b1, 1'b1, {(W-1){1'b0}}} : {1'b0, ~q[W-1:0] + 1'b1};
    end else begin
      ov = big || q[W] || q[W-1];
      r  = ov ? {1'b1, 1'b0, {(W-1){1'b1}}} : {1'b0, q[W-1:0]};
    end
    return r;
  endfunction

  state_e state_q;

  // Datapath registers
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_r_q, s_i_q;
  logic [PW-1:0]        den_q;
  logic [DVW-1:0]       dv_re_q, dv_im_q;
  logic [PW-1:0]        rm_re_q, rm_im_q;
  logic [W:0]           q_re_q, q_im_q;
  logic                 big_re_q, big_im_q, neg_re_q, neg_im_q;
  logic [CNTW-1:0]      cnt_q;

  // Output registers
  logic         valid_q, dz_q, ovf_q;
  logic [W-1:0] yre_q, yim_q;

  // Products straight from the queue head
  logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir, m_sr, m_si;
  assign m_rr = $signed(head_i.a_re) * $signed(head_i.b_re);
  assign m_ii = $signed(head_i.a_im) * $signed(head_i.b_im);
  assign m_ri = $signed(head_i.a_re) * $signed(head_i.b_im);
  assign m_ir = $signed(head_i.a_im) * $signed(head_i.b_re);
  assign m_sr = $signed(head_i.b_re) * $signed(head_i.b_re);
  assign m_si = $signed(head_i.b_im) * $signed(head_i.b_im);

  // Fast path: add, subtract, zero divisor
  logic [W:0]  f_re, f_im, fs_re, fs_im;
  always_comb begin
    if (head_i.cmd == cau_pkg::CMD_SUB) begin
      f_re = {head_i.a_re[W-1], head_i.a_re} - {head_i.b_re[W-1], head_i.b_re};
      f_im = {head_i.a_im[W-1], head_i.a_im} - {head_i.b_im[W-1], head_i.b_im};
    end else if (head_i.dz) begin
      f_re = {head_i.a_re[W-1], head_i.a_re};
      f_im = {head_i.a_im[W-1], head_i.a_im};
    end else begin
      f_re = {head_i.a_re[W-1], head_i.a_re} + {head_i.b_re[W-1], head_i.b_re};
      f_im = {head_i.a_im[W-1], head_i.a_im} + {head_i.b_im[W-1], head_i.b_im};
    end
    fs_re = sat({{(MW-W-1){f_re[W]}}, f_re});
    fs_im = sat({{(MW-W-1){f_im[W]}}, f_im});
  end

  // Multiply combine: floor shift by the fraction bits
  logic [NW-1:0] mc_re, mc_im;
  logic [W:0]    ms_re, ms_im;
  assign mc_re = {p_rr_q[PW-1], p_rr_q} - {p_ii_q[PW-1], p_ii_q};
  assign mc_im = {p_ri_q[PW-1], p_ri_q} + {p_ir_q[PW-1], p_ir_q};
  assign ms_re = sat(mc_re[NW-1:F]);
  assign ms_im = sat(mc_im[NW-1:F]);

  // Divide setup: numerators and denominator
  logic [NW-1:0] n_re, n_im, g_re, g_im;
  logic [PW-1:0] den;
  assign n_re = {p_rr_q[PW-1], p_rr_q} + {p_ii_q[PW-1], p_ii_q};
  assign n_im = {p_ir_q[PW-1], p_ir_q} - {p_ri_q[PW-1], p_ri_q};
  assign g_re = n_re[NW-1] ? (~n_re + 1'b1) : n_re;
  assign g_im = n_im[NW-1] ? (~n_im + 1'b1) : n_im;
  assign den  = s_r_q + s_i_q;

  // One restoring division step for each part
  logic [PW:0]   r_re, r_im;
  logic          ge_re, ge_im;
  logic [PW-1:0] rn_re, rn_im;
  assign r_re  = {rm_re_q, dv_re_q[DVW-1]};
  assign r_im  = {rm_im_q, dv_im_q[DVW-1]};
  assign ge_re = (r_re >= {1'b0, den_q});
  assign ge_im = (r_im >= {1'b0, den_q});
  assign rn_re = ge_re ? PW'(r_re - {1'b0, den_q}) : r_re[PW-1:0];
  assign rn_im = ge_im ? PW'(r_im - {1'b0, den_q}) : r_im[PW-1:0];

  logic [W:0] fd_re, fd_im;
  assign fd_re = fin(neg_re_q, big_re_q, q_re_q);
  assign fd_im = fin(neg_im_q, big_im_q, q_im_q);

  assign deq_o.pop = (state_q == S_IDLE) && !empty_i;

  // Control and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      dz_q    <= 1'b0;
      ovf_q   <= 1'b0;
      yre_q   <= '0;
      yim_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          valid_q <= !empty_i && (head_i.kind == cau_pkg::KIND_FAST);
          if (!empty_i) begin
            case (head_i.kind)
              cau_pkg::KIND_FAST: begin
                yre_q   <= fs_re[W-1:0];
                yim_q   <= fs_im[W-1:0];
                ovf_q   <= fs_re[W] | fs_im[W];
                dz_q    <= head_i.dz;
              end
              cau_pkg::KIND_MUL: state_q <= S_MUL;
              cau_pkg::KIND_DIV: state_q <= S_PREP;
              default:           state_q <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          valid_q <= 1'b1;
          yre_q   <= ms_re[W-1:0];
          yim_q   <= ms_im[W-1:0];
          ovf_q   <= ms_re[W] | ms_im[W];
          dz_q    <= 1'b0;
          state_q <= S_IDLE;
        end
        S_PREP: begin
          valid_q <= 1'b0;
          cnt_q   <= CNTW'(DVW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          valid_q <= 1'b0;
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          valid_q <= 1'b1;
          yre_q   <= fd_re[W-1:0];
          yim_q   <= fd_im[W-1:0];
          ovf_q   <= fd_re[W] | fd_im[W];
          dz_q    <= 1'b0;
          state_q <= S_IDLE;
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: products, dividends, remainders, quotients
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        p_rr_q <= m_rr;
        p_ii_q <= m_ii;
        p_ri_q <= m_ri;
        p_ir_q <= m_ir;
        s_r_q  <= m_sr;
        s_i_q  <= m_si;
      end
      S_PREP: begin
        den_q    <= den;
        dv_re_q  <= {g_re, {F{1'b0}}};
        dv_im_q  <= {g_im, {F{1'b0}}};
        neg_re_q <= n_re[NW-1];
        neg_im_q <= n_im[NW-1];
        rm_re_q  <= '0;
        rm_im_q  <= '0;
        q_re_q   <= '0;
        q_im_q   <= '0;
        big_re_q <= 1'b0;
        big_im_q <= 1'b0;
      end
      S_DIV: begin
        dv_re_q  <= {dv_re_q[DVW-2:0], 1'b0};
        dv_im_q  <= {dv_im_q[DVW-2:0], 1'b0};
        rm_re_q  <= rn_re;
        rm_im_q  <= rn_im;
        q_re_q   <= {q_re_q[W-1:0], ge_re};
        q_im_q   <= {q_im_q[W-1:0], ge_im};
        big_re_q <= big_re_q | q_re_q[W];
        big_im_q <= big_im_q | q_im_q[W];
      end
      default: begin
      end
    endcase
  end

  assign valid_o    = valid_q;
  assign y_re_o     = yre_q;
  assign y_im_o     = yim_q;
  assign div_zero_o = dz_q;
  assign overflow_o = ovf_q;

endmodule

### hw/rtl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front, queue and back part.
//
//   channel   direction  handshake                  payload
//   command   in         start high, busy low       cmd_i, a_re_i, a_im_i, b_re_i, b_im_i
//   result    out        valid_o strobe, one cycle  y_re_o, y_im_o, div_zero_o, overflow_o
//
// Add, subtract and divide by zero finish in the back part straight from the
// queue head and follow each other every cycle while the queue is not empty;
// multiply passes S_MUL; divide passes S_PREP, S_DIV (the bit-serial restoring
// divider, 81 quotient steps) and S_FIN. Each transaction is registered in the
// queue before the back part sees it. busy is high while the two-entry queue is full.
// Reset clears the queue and the back state. The receiver cannot stall: each result shows for one cycle.
module complex_arithmetic_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd_i,
  input  logic [cau_pkg::W-1:0] a_re_i,
  input  logic [cau_pkg::W-1:0] a_im_i,
  input  logic [cau_pkg::W-1:0] b_re_i,
  input  logic [cau_pkg::W-1:0] b_im_i,
  output logic                  valid_o,
  output logic [cau_pkg::W-1:0] y_re_o,
  output logic [cau_pkg::W-1:0] y_im_o,
  output logic                  div_zero_o,
  output logic                  overflow_o
);

  cau_pkg::item_t item, head;
  cau_pkg::deq_t  deq;
  logic           q_empty, q_full;

  cau_front u_front (
    .cmd_i  (cmd_i),
    .a_re_i (a_re_i),
    .a_im_i (a_im_i),
    .b_re_i (b_re_i),
    .b_im_i (b_im_i),
    .item_o (item)
  );

  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (start),
    .item_i  (item),
    .deq_i   (deq),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cau_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (q_empty),
    .deq_o      (deq),
    .valid_o    (valid_o),
    .y_re_o     (y_re_o),
    .y_im_o     (y_im_o),
    .div_zero_o (div_zero_o),
    .overflow_o (overflow_o)
  );

  assign busy = q_full;

  // A zero-divisor result is a copy of a and never saturates
  a_dz_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(div_zero_o && overflow_o))
    else $error("divide by zero result flagged overflow");

  // An accepted transaction into an empty queue is visible next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && q_empty) |=> !q_empty)
    else $error("accepted transaction lost in queue");

  // The back part never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq.pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
